### rtl/core/arx_feistel_sponge_xof_core_defines.svh
// Assertion macros for the sponge core checker
`ifndef ARX_FEISTEL_SPONGE_XOF_CORE_DEFINES_SVH
`define ARX_FEISTEL_SPONGE_XOF_CORE_DEFINES_SVH
// implication checked every clock outside reset
`define AFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define AFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/core/afsx_pkg.sv
// ----------------------------------------------------------------------------
// afsx_pkg
// Types, constants and round-constant table for the ARX Feistel sponge core.
// ----------------------------------------------------------------------------
package afsx_pkg;

  localparam int LANES     = 16;
  localparam int HALF      = 8;
  localparam int MAX_ROUND = 16;

  localparam logic [1:0] MODE_INIT   = 2'd0;
  localparam logic [1:0] MODE_ABSORB = 2'd1;
  localparam logic [1:0] MODE_FINAL  = 2'd2;
  localparam logic [1:0] MODE_SQUEEZE = 2'd3;

  localparam logic [0:0] REG_WIDE_RATE  = 1'd0;
  localparam logic [0:0] REG_DOMAIN_TAG = 1'd1;

  localparam logic [63:0] IV0 = 64'h0000004148534F49;
  localparam logic [63:0] IV1 = 64'h000064656E676973;
  localparam logic [63:0] IV2 = 64'h00006874696C6964;

  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;
  localparam logic [63:0] SEED   = 64'h494F5348415F5652 ^ 64'h0000C001D00D5EED;

  typedef logic [63:0] lane_t;
  typedef lane_t [HALF-1:0] half_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_PERM,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       do_init;
    logic       do_absorb;
    logic       do_pad;
    logic       perm_load;
    logic       perm_round;
    logic       perm_store;
    logic       pos_clear;
    logic [3:0] round_idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rate_full;
    logic wide;
  } dp_stat_t;

  // splitmix64 output for stream index n (elaboration-time use)
  function automatic lane_t splitmix(input int n);
    lane_t s;
    lane_t z;
    s = SEED;
    for (int k = 0; k <= n; k++) s = s + GOLDEN;
    z = s;
    z = (z ^ (z >> 30)) * MIX1;
    z = (z ^ (z >> 27)) * MIX2;
    z = z ^ (z >> 31);
    return z;
  endfunction

  function automatic lane_t rotl(input lane_t x, input int r);
    return (r % 64 == 0) ? x : ((x << (r % 64)) | (x >> (64 - (r % 64))));
  endfunction

  function automatic int rot_a(input int i);
    case (i)
      0: return 63; 1: return 19; 2: return 39; 3: return 15;
      4: return 23; 5: return 31; 6: return 11; default: return 5;
    endcase
  endfunction

  function automatic int rot_b(input int i);
    case (i)
      0: return 21; 1: return 3;  2: return 31; 3: return 33;
      4: return 45; 5: return 5;  6: return 17; default: return 7;
    endcase
  endfunction

  function automatic int rot_g(input int i);
    case (i)
      0: return 25; 1: return 45; 2: return 51; 3: return 5;
      4: return 63; 5: return 47; 6: return 7;  default: return 1;
    endcase
  endfunction

endpackage

### rtl/core/afsx_ctrl.sv
// ----------------------------------------------------------------------------
// afsx_ctrl
// Sequencer: decodes item kinds, counts rounds and emitted lanes.
// ----------------------------------------------------------------------------
module afsx_ctrl import afsx_pkg::*; #(
  parameter int ROUNDS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [3:0] out_index,
  output logic       out_last,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  localparam int RW = $clog2(ROUNDS + 1);

  state_t        state, state_next;
  logic [RW-1:0] round;
  logic [3:0]    lane;
  logic          emit_after;
  logic          accept;
  logic          last_rnd;
  logic [3:0]    lane_max;

  assign accept   = in_valid && in_ready;
  assign last_rnd = (round == RW'(ROUNDS - 1));
  assign lane_max = stat.wide ? 4'd11 : 4'd7;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_FINAL) state_next = ST_PAD;
          else if (in_mode == MODE_SQUEEZE) state_next = ST_PERM;
          else if (in_mode == MODE_ABSORB && stat.rate_full) state_next = ST_PERM;
        end
      end
      ST_PAD:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_PERM;
      ST_PERM: if (last_rnd) state_next = emit_after ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_ready && lane == lane_max) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.do_init   = accept && in_mode == MODE_INIT;
        cmd.do_absorb = accept && in_mode == MODE_ABSORB;
        cmd.perm_load = accept && (in_mode == MODE_SQUEEZE ||
                        (in_mode == MODE_ABSORB && stat.rate_full));
        cmd.pos_clear = accept && in_mode == MODE_ABSORB && stat.rate_full;
      end
      ST_PAD: begin
        cmd.do_pad    = 1'b1;
        cmd.pos_clear = 1'b1;
      end
      // padded state goes into the working halves
      ST_LOAD: cmd.perm_load = 1'b1;
      ST_PERM: begin
        cmd.perm_round = 1'b1;
        cmd.perm_store = last_rnd;
      end
      ST_EMIT: out_valid = 1'b1;
      default: ;
    endcase
    cmd.round_idx = 4'(round);
  end

  assign out_index = lane;
  assign out_last  = (lane == lane_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round      <= '0;
      lane       <= '0;
      emit_after <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) emit_after <= (in_mode == MODE_FINAL || in_mode == MODE_SQUEEZE);
      if (state == ST_PERM) round <= last_rnd ? '0 : round + 1'b1;
      if (state == ST_EMIT && out_ready) lane <= (lane == lane_max) ? 4'd0 : lane + 4'd1;
    end
  end

endmodule

### rtl/core/afsx_dp.sv
// ----------------------------------------------------------------------------
// afsx_dp
// State lanes, byte absorb, padding and one Feistel round per cycle.
// ----------------------------------------------------------------------------
module afsx_dp import afsx_pkg::*; #(
  parameter int ROUNDS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat,
  input  logic [7:0] data_byte,
  input  logic       cfg_wide,
  input  logic [7:0] cfg_tag,
  input  logic [3:0] lane_sel,
  output lane_t      lane_value
);

  lane_t [LANES-1:0] st;
  half_t      lh, rh;
  logic [6:0] pos;
  logic       wide;
  half_t      box;
  logic [6:0] pos_inc;

  assign pos_inc   = pos + 7'd1;
  assign stat = '{rate_full: (pos_inc == (wide ? 7'd96 : 7'd64)), wide: wide};
  assign lane_value = st[lane_sel];

  // round constants from the elaboration-time table
  function automatic lane_t rc(input logic [3:0] r, input int i);
    lane_t v;
    v = '0;
    for (int k = 0; k < MAX_ROUND; k++)
      if (r == 4'(k)) v = splitmix(k * 8 + i);
    return v;
  endfunction

  // ARX box over the right half
  always_comb begin
    half_t x;
    lane_t t;
    x = rh;
    for (int i = 0; i < 8; i++) x[i] = x[i] + rotl(x[(i + 1) % 8], rot_a(i));
    for (int i = 0; i < 8; i++) x[i] = x[i] ^ rotl(x[(i + 2) % 8], (64 - rot_b(i)) % 64);
    for (int i = 0; i < 8; i++) x[i] = x[i] + rc(cmd.round_idx, i);
    t = '0;
    for (int i = 0; i < 8; i++) t = t ^ x[i];
    for (int i = 0; i < 8; i++) x[i] = x[i] ^ rotl(t, rot_g(i));
    box = x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '0;
      pos  <= '0;
      wide <= 1'b0;
    end else begin
      if (cmd.do_init) begin
        st    <= '0;
        st[0] <= IV0;
        st[1] <= IV1;
        st[2] <= IV2;
        st[3] <= {56'd0, cfg_tag};
        wide  <= cfg_wide;
        pos   <= '0;
      end
      if (cmd.do_absorb) begin
        st[pos[6:3]][pos[2:0]*8 +: 8] <= st[pos[6:3]][pos[2:0]*8 +: 8] ^ data_byte;
        pos <= pos_inc;
      end
      if (cmd.do_pad) begin
        if (pos == (wide ? 7'd95 : 7'd63))
          st[pos[6:3]][63:56] <= st[pos[6:3]][63:56] ^ 8'h81;
        else begin
          st[pos[6:3]][pos[2:0]*8 +: 8] <= st[pos[6:3]][pos[2:0]*8 +: 8] ^ 8'h01;
          if (wide) st[11][63:56] <= st[11][63:56] ^ 8'h80;
          else      st[7][63:56]  <= st[7][63:56] ^ 8'h80;
        end
      end
      if (cmd.pos_clear) pos <= '0;
      if (cmd.perm_store) begin
        for (int i = 0; i < 8; i++) begin
          if (ROUNDS % 2 == 1) begin
            st[i]     <= lh[i] ^ box[i];
            st[8 + i] <= rh[i];
          end else begin
            st[i]     <= rh[i];
            st[8 + i] <= lh[i] ^ box[i];
          end
        end
      end
    end
  end

  // working halves for the permutation
  always_ff @(posedge clk) begin
    if (cmd.perm_load && !cmd.do_pad) begin
      for (int i = 0; i < 8; i++) begin
        lh[i] <= st[i];
        rh[i] <= st[8 + i];
      end
      if (cmd.do_absorb) begin
        if (pos[6])
          rh[pos[5:3]][pos[2:0]*8 +: 8] <= st[8 + pos[5:3]][pos[2:0]*8 +: 8] ^ data_byte;
        else
          lh[pos[5:3]][pos[2:0]*8 +: 8] <= st[pos[5:3]][pos[2:0]*8 +: 8] ^ data_byte;
      end
    end else if (cmd.perm_round) begin
      for (int i = 0; i < 8; i++) begin
        lh[i] <= rh[i];
        rh[i] <= lh[i] ^ box[i];
      end
    end
  end

endmodule

### rtl/core/arx_feistel_sponge_xof_core.sv
// ----------------------------------------------------------------------------
// arx_feistel_sponge_xof_core
// Sponge XOF over a 1024-bit state with an ARX Feistel permutation.
// ----------------------------------------------------------------------------
// Init and plain absorb beats are taken directly in the idle state.
// Rate-filling absorb: load, then the Feistel rounds (one Feistel round per cycle).
// Finalize: pad, load and rounds, then 8 or 12 lane beats; continue: load and rounds.
// No input beat is taken while a permutation or a lane emission runs.
// Reset: state zero, 64-byte rate, registers zero.
module arx_feistel_sponge_xof_core import afsx_pkg::*; #(
  parameter int ROUNDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] mode, [9:2] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] lane_value
  output logic [3:0]  m_tuser,   // [3:0] lane_index
  output logic        m_tlast
);

  logic       wide_rate;
  logic [7:0] domain_tag;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wide_rate  <= 1'b0;
      domain_tag <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDE_RATE:  wide_rate  <= cfg_data[0];
        REG_DOMAIN_TAG: domain_tag <= cfg_data;
        default: ;
      endcase
    end
  end

  afsx_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
    .clk, .rst,
    .in_valid (s_tvalid),
    .in_mode  (s_tdata[1:0]),
    .in_ready (s_tready),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_index(m_tuser),
    .out_last (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

  afsx_dp #(.ROUNDS(ROUNDS)) u_dp (
    .clk, .rst,
    .cmd       (cmd),
    .stat      (stat),
    .data_byte (s_tdata[9:2]),
    .cfg_wide  (wide_rate),
    .cfg_tag   (domain_tag),
    .lane_sel  (m_tuser),
    .lane_value(m_tdata)
  );

endmodule

### rtl/core/afsx_checker.sv
// ----------------------------------------------------------------------------
// afsx_checker
// Port-level checks on the sponge core, bound to the top level.
// ----------------------------------------------------------------------------
`include "arx_feistel_sponge_xof_core_defines.svh"
module afsx_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);
  `AFS_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready, "input taken during emit")
  `AFS_ASSERT_IMP(a_idx_range, m_tvalid, m_tuser <= 4'd11, "lane index out of range")
  `AFS_ASSERT_IMP(a_last_idx, m_tvalid && m_tlast, m_tuser == 4'd7 || m_tuser == 4'd11, "bad last lane")
  `AFS_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "beat dropped")
endmodule

bind arx_feistel_sponge_xof_core afsx_checker u_chk (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);
